// ===== rtl/four_way_duplicate_filter_defines.svh =====
// Assertion macros used by the checker file fwdf_chk.sv.
`ifndef FOUR_WAY_DUPLICATE_FILTER_DEFINES_SVH
`define FOUR_WAY_DUPLICATE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define FWDF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define FWDF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fwdf_pkg.sv =====
`default_nettype none

package fwdf_pkg;

	localparam int unsigned VID_W = 32;

	localparam logic [1:0] MODE_VERTEX   = 2'd0;
	localparam logic [1:0] MODE_PASS_END = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [VID_W-1:0] vertex_id;
	} in_t;

	typedef struct packed {
		logic [VID_W-1:0] unique_vertex;
		logic             pass_end;
	} out_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic commit_vertex;
		logic commit_marker;
		logic ptr_reset;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       hit;
		logic       out_free;
		logic       clr_last;
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/fwdf_ram.sv =====
`default_nettype none

module fwdf_ram #(
	parameter int unsigned WIDTH = 18,
	parameter int unsigned DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fwdf_ctrl.sv =====
`default_nettype none

module fwdf_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire fwdf_pkg::ctrl_sts_t  sts,
	output fwdf_pkg::ctrl_cmd_t       cmd
);

	import fwdf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				case (sts.mode)
					MODE_VERTEX: begin
						if (sts.hit || sts.out_free) begin
							state_d = ST_IDLE;
						end
					end
					MODE_PASS_END: begin
						if (sts.out_free) begin
							state_d = ST_IDLE;
						end
					end
					MODE_CLEAR: state_d = ST_CLEAR;
					default:    state_d = ST_IDLE;
				endcase
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_LOOKUP: begin
				case (sts.mode)
					MODE_VERTEX: begin
						cmd.commit_vertex = !sts.hit && sts.out_free;
					end
					MODE_PASS_END: begin
						cmd.commit_marker = sts.out_free;
						cmd.ptr_reset     = sts.out_free;
					end
					MODE_CLEAR: cmd.ptr_reset = 1'b1;
					default:    cmd.ptr_reset = 1'b0;
				endcase
			end
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/fwdf_dp.sv =====
`default_nettype none

module fwdf_dp #(
	parameter int unsigned INDEX_BITS = 14,
	parameter int unsigned WAY_COUNT  = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fwdf_pkg::in_t       in_data,
	input  wire fwdf_pkg::ctrl_cmd_t cmd,
	output fwdf_pkg::ctrl_sts_t      sts,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output fwdf_pkg::out_t           out_data
);

	import fwdf_pkg::*;

	localparam int unsigned TAG_W = VID_W - INDEX_BITS;
	localparam int unsigned DEPTH = 1 << INDEX_BITS;
	localparam int unsigned PTR_W = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

	in_t                   item_q;
	logic [INDEX_BITS-1:0] clr_addr_q;
	logic [PTR_W-1:0]      ptr_q;
	logic                  out_valid_q;
	out_t                  out_data_q;

	logic [TAG_W-1:0]      rdata [WAY_COUNT];
	logic [TAG_W-1:0]      item_tag;
	logic [INDEX_BITS-1:0] item_row;
	logic [INDEX_BITS-1:0] waddr;
	logic [TAG_W-1:0]      wdata;
	logic                  hit;
	logic                  out_free;

	assign item_tag = item_q.vertex_id[VID_W-1:INDEX_BITS];
	assign item_row = item_q.vertex_id[INDEX_BITS-1:0];
	assign waddr    = cmd.clr_step ? clr_addr_q : item_row;
	assign wdata    = cmd.clr_step ? {TAG_W{1'b1}} : item_tag;
	assign out_free = !out_valid_q || out_ready;

	for (genvar w = 0; w < WAY_COUNT; w++) begin : g_way
		fwdf_ram #(
			.WIDTH(TAG_W),
			.DEPTH(DEPTH)
		) u_tags (
			.clk  (clk),
			.we   (cmd.clr_step || (cmd.commit_vertex && (ptr_q == PTR_W'(w)))),
			.waddr(waddr),
			.wdata(wdata),
			.re   (cmd.accept),
			.raddr(in_data.vertex_id[INDEX_BITS-1:0]),
			.rdata(rdata[w])
		);
	end

	always_comb begin
		hit = 1'b0;
		for (int w = 0; w < WAY_COUNT; w++) begin
			if (rdata[w] == item_tag) begin
				hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			ptr_q      <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + INDEX_BITS'(1);
			end
			if (cmd.ptr_reset) begin
				ptr_q <= '0;
			end else if (cmd.commit_vertex) begin
				ptr_q <= (ptr_q == PTR_W'(WAY_COUNT - 1)) ? '0 : ptr_q + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit_vertex || cmd.commit_marker) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit_vertex) begin
			out_data_q.unique_vertex <= item_q.vertex_id;
			out_data_q.pass_end      <= 1'b0;
		end else if (cmd.commit_marker) begin
			out_data_q.unique_vertex <= '0;
			out_data_q.pass_end      <= 1'b1;
		end
	end

	assign sts.mode     = item_q.mode;
	assign sts.hit      = hit;
	assign sts.out_free = out_free;
	assign sts.clr_last = &clr_addr_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/four_way_duplicate_filter.sv =====
`default_nettype none

// Drops repeated vertex ids from a stream. The low INDEX_BITS bits of an id pick a row and
// the high bits form its tag; if none of the WAY_COUNT tag memories holds that tag in the
// row, the id is passed on and its tag is written to the way named by a round-robin victim
// pointer. An end-of-pass transaction returns a marker (pass_end set, id zero) and resets
// the pointer; a clear transaction returns nothing, resets the pointer and rewrites every
// entry with the all-ones empty mark; an id whose tag is all ones hits any such empty entry.
// A vertex or end-of-pass transaction is handled in order: first the row is read from the
// registered-read tag memories, then all ways are compared and the victim way is written.
// The second step waits only while the output register still holds an untaken result.
// After reset and after each clear transaction the block sweeps all 2**INDEX_BITS rows
// of the memories, one row per cycle, with in_ready low.
module four_way_duplicate_filter #(
	parameter int unsigned INDEX_BITS = 14,
	parameter int unsigned WAY_COUNT  = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire fwdf_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output fwdf_pkg::out_t      out_data
);

	import fwdf_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	fwdf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fwdf_dp #(
		.INDEX_BITS(INDEX_BITS),
		.WAY_COUNT (WAY_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// ===== rtl/fwdf_chk.sv =====
`default_nettype none

`include "four_way_duplicate_filter_defines.svh"

module fwdf_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire fwdf_pkg::out_t out_data
);

	import fwdf_pkg::*;

	// An accepted transaction keeps the input closed while its lookup runs.
	`FWDF_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input open during lookup")

	// A new result is loaded only while a lookup is in progress.
	`FWDF_ASSERT_IMP(a_result_src, out_valid && !$past(out_valid), !$past(in_ready), "no lookup")

	`FWDF_ASSERT_IMP(a_mark_id, out_valid && out_data.pass_end, out_data.unique_vertex == '0, "marker id")

	`FWDF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed")

endmodule

bind four_way_duplicate_filter fwdf_chk u_chk (.*);

`default_nettype wire
